// ===== sv/mpfd_pkg.sv =====
package mpfd_pkg;

  // Field widths of the date and result words.
  localparam int YEAR_W  = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int JD_W    = 22;
  localparam int PHASE_W = 7;

  // Fractional bits of the phase arithmetic.
  localparam int FRAC_BITS = 40;

  // Internal widths of the Julian day datapath.
  localparam int Y_W    = 12;  // full year, up to 2127
  localparam int A_W    = 13;  // shifted year term, below 8192
  localparam int Q_W    = 7;   // century count, up to 69
  localparam int QP_W   = 26;  // century reciprocal product
  localparam int SEV_W  = 16;  // seven times the shifted year
  localparam int E_W    = 8;   // three times one more than the century count
  localparam int MTERM_W = 9;  // month day-count term

  localparam logic [Y_W-1:0]    YEAR_BASE   = 12'd2000;
  localparam logic [A_W-1:0]    A_BASE      = 13'd4716;
  localparam logic [4:0]        MONTH_SHIFT = 5'd9;
  localparam logic [4:0]        MONTHS_1    = 5'd12;
  localparam logic [4:0]        MONTHS_2    = 5'd24;
  localparam logic [A_W-1:0]    CENT_BIAS   = 13'd83;
  localparam logic [A_W-1:0]    CENT_DIV    = 13'd100;
  localparam logic [QP_W-1:0]   CENT_RECIP  = 26'd5242;  // just under 2^19 / 100
  localparam int                CENT_SHIFT  = 19;
  localparam logic [JD_W-1:0]   JD_BASE     = 22'd1729279;
  localparam logic [JD_W-1:0]   YEAR_DAYS   = 22'd367;
  localparam logic [JD_W-1:0]   DAY_BIAS    = 22'd38;
  localparam logic [SEV_W-1:0]  SEV_MULT    = 16'd7;
  localparam logic [E_W-1:0]    E_MULT      = 8'd3;

  // Floor of 275 * month / 9 for every 4-bit month code.
  localparam logic [MTERM_W-1:0] MONTH_TERM [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd213,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd366, 9'd397, 9'd427, 9'd458
  };

  // Rounded num * 2^FRAC_BITS / den for num < den, by restoring long division.
  function automatic logic [63:0] scaled_ratio(input logic [63:0] num,
                                               input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] q;
    begin
      rem = num;
      q   = 64'd0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        q   = q << 1;
        if (rem >= den) begin
          rem  = rem - den;
          q[0] = 1'b1;
        end
      end
      rem = rem << 1;
      if (rem >= den) begin
        q = q + 64'd1;
      end
      return q;
    end
  endfunction

  // Reciprocal of the synodic month and the new-moon offset in fixed point.
  localparam logic [63:0] RECIP_FULL = scaled_ratio(64'd10000000000, 64'd295305902778);
  localparam logic [63:0] OFFS_FULL  = scaled_ratio(64'd3033, 64'd10000);

  localparam int RECIP_W    = $clog2(RECIP_FULL + 64'd1);
  localparam int RECIP_LO_W = RECIP_W / 2;
  localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
  localparam int M_W        = JD_W + 1;
  localparam int PP_LO_W    = M_W + RECIP_LO_W;
  localparam int PP_HI_W    = M_W + RECIP_HI_W;
  localparam int SUM_W      = M_W + RECIP_W;
  localparam int PROD_W     = FRAC_BITS + 1;
  localparam int PCT_W      = FRAC_BITS + PHASE_W;

  localparam logic [RECIP_W-1:0]   RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [FRAC_BITS-1:0] OFFS  = OFFS_FULL[FRAC_BITS-1:0];
  localparam logic [PCT_W-1:0]     PCT_SCALE = PCT_W'(100);

  // Julian day word passed between the two halves of the pipeline.
  typedef struct packed {
    logic            valid;
    logic [JD_W-1:0] n;
  } jd_word_t;

endpackage

// ===== sv/mpfd_date_if.sv =====
interface mpfd_date_if;
  import mpfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year_offset;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;

  modport source(output valid, year_offset, month, day_of_month, input ready);
  modport sink(input valid, year_offset, month, day_of_month, output ready);
endinterface

// ===== sv/mpfd_result_if.sv =====
interface mpfd_result_if;
  import mpfd_pkg::*;

  logic               valid;
  logic               ready;
  logic [JD_W-1:0]    julian_day_whole;
  logic [PHASE_W-1:0] moon_phase;

  modport source(output valid, julian_day_whole, moon_phase, input ready);
  modport sink(input valid, julian_day_whole, moon_phase, output ready);
endinterface

// ===== sv/moon_phase_from_date.sv =====
// Moon phase from a calendar date. Each date word (year minus 2000, month,
// day of month) yields one result word holding the whole part N of the
// Gregorian Julian day JD = N + 0.5 and the moon phase as a truncated
// percent from 0 to 99, where 0 is new moon, 25 first quarter, 50 full and
// 75 last quarter. Dates are not checked: a month outside 1 to 12 or a day
// past the end of its month goes through the same formula, so the date rolls
// into a neighboring month. The phase uses unsigned fixed point with 40
// fractional bits, so a phase sitting right on a percent boundary can differ
// by one from a single-precision evaluation. The block is a seven-stage
// pipeline with no state across words: a date word is taken in every cycle
// while the output is not stalled, one result per cycle sustained. The
// multiply by the synodic-month reciprocal is split into two narrow partial
// products, both formed in the fourth stage.
module moon_phase_from_date (
  input  logic          clk,
  input  logic          rst_n,
  mpfd_date_if.sink     in_date,
  mpfd_result_if.source out_result
);
  import mpfd_pkg::*;

  // Link between the calendar half and the phase half of the pipeline.
  jd_word_t jd;
  logic     jd_ready;

  // Stages one to three turn the date into the whole Julian day using only
  // additions, subtractions, constant multiplies, a month table and a
  // reciprocal estimate of the century count with a single correction step.
  mpfd_julian u_julian (
    .clk        (clk),
    .rst_n      (rst_n),
    .date       (in_date),
    .jd_o       (jd),
    .jd_ready_i (jd_ready)
  );

  // Stages four to seven scale 2N + 1 by the fixed-point reciprocal of the
  // synodic month, keep the fraction, subtract the new-moon offset and scale
  // the result to a percent. The last stage is the output register; every
  // stage moves on its own when the one after it is empty or draining, so
  // a stall at the output loses and repeats nothing.
  mpfd_phase u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .jd_i       (jd),
    .jd_ready_o (jd_ready),
    .res        (out_result)
  );

endmodule

// ===== sv/mpfd_julian.sv =====
module mpfd_julian (
  input  logic              clk,
  input  logic              rst_n,
  mpfd_date_if.sink         date,
  output mpfd_pkg::jd_word_t jd_o,
  input  logic              jd_ready_i
);
  import mpfd_pkg::*;

  logic [2:0] v_r;
  logic [2:0] en;

  // Stage 1: full year, shifted year and month term.
  logic [Y_W-1:0]     s1_year_r;
  logic [A_W-1:0]     s1_a_r;
  logic [MTERM_W-1:0] s1_mterm_r;
  logic [DAY_W-1:0]   s1_day_r;
  // Stage 2: positive sum, century estimate, seven-quarters term.
  logic [JD_W-1:0]    s2_sum_r;
  logic [A_W-1:0]     s2_x_r;
  logic [Q_W-1:0]     s2_qest_r;
  logic [SEV_W-3:0]   s2_sev_r;
  // Stage 3: whole Julian day.
  logic [JD_W-1:0]    s3_n_r;

  logic [Y_W-1:0]     year_nxt;
  logic [4:0]         mp9;
  logic [1:0]         carry;
  logic [A_W-1:0]     a_nxt;
  logic [A_W-1:0]     x_nxt;
  logic [QP_W-1:0]    qprod;
  logic [SEV_W-1:0]   sev_full;
  logic [JD_W-1:0]    sum_nxt;
  logic [A_W-1:0]     hund;
  logic [A_W-1:0]     rem;
  logic [Q_W-1:0]     q;
  logic [E_W-1:0]     e_full;
  logic [JD_W-1:0]    n_nxt;

  always_comb begin
    en[2] = !v_r[2] || jd_ready_i;
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign date.ready = en[0];

  always_comb begin
    year_nxt = Y_W'(date.year_offset) + YEAR_BASE;
    mp9      = 5'(date.month) + MONTH_SHIFT;
    if (mp9 >= MONTHS_2) begin
      carry = 2'd2;
    end else if (mp9 >= MONTHS_1) begin
      carry = 2'd1;
    end else begin
      carry = 2'd0;
    end
    a_nxt = A_W'(year_nxt) + A_BASE + A_W'(carry);
  end

  always_comb begin
    sum_nxt  = JD_BASE + JD_W'(s1_year_r) * YEAR_DAYS + JD_W'(s1_mterm_r)
             + JD_W'(s1_day_r) + DAY_BIAS;
    x_nxt    = s1_a_r + CENT_BIAS;
    qprod    = QP_W'(x_nxt) * CENT_RECIP;
    sev_full = SEV_W'(s1_a_r) * SEV_MULT;
  end

  // The reciprocal estimate of the century count is at most one low.
  always_comb begin
    hund   = A_W'(s2_qest_r) * CENT_DIV;
    rem    = s2_x_r - hund;
    q      = (rem >= CENT_DIV) ? s2_qest_r + Q_W'(1) : s2_qest_r;
    e_full = (E_W'(q) + E_W'(1)) * E_MULT;
    n_nxt  = s2_sum_r - JD_W'(s2_sev_r) - JD_W'(e_full[E_W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= date.valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && date.valid) begin
      s1_year_r  <= year_nxt;
      s1_a_r     <= a_nxt;
      s1_mterm_r <= MONTH_TERM[date.month];
      s1_day_r   <= date.day_of_month;
    end
    if (en[1] && v_r[0]) begin
      s2_sum_r  <= sum_nxt;
      s2_x_r    <= x_nxt;
      s2_qest_r <= qprod[QP_W-1:CENT_SHIFT];
      s2_sev_r  <= sev_full[SEV_W-1:2];
    end
    if (en[2] && v_r[1]) begin
      s3_n_r <= n_nxt;
    end
  end

  assign jd_o.valid = v_r[2];
  assign jd_o.n     = s3_n_r;

endmodule

// ===== sv/mpfd_phase.sv =====
module mpfd_phase (
  input  logic               clk,
  input  logic               rst_n,
  input  mpfd_pkg::jd_word_t jd_i,
  output logic               jd_ready_o,
  mpfd_result_if.source      res
);
  import mpfd_pkg::*;

  logic [3:0] v_r;
  logic [3:0] en;

  logic [JD_W-1:0]      p1_n_r;
  logic [PP_LO_W-1:0]   p1_pp_lo_r;
  logic [PP_HI_W-1:0]   p1_pp_hi_r;
  logic [JD_W-1:0]      p2_n_r;
  logic [FRAC_BITS-1:0] p2_frac_r;
  logic [JD_W-1:0]      p3_n_r;
  logic [FRAC_BITS-1:0] p3_phase_r;
  logic [JD_W-1:0]      p4_n_r;
  logic [PHASE_W-1:0]   p4_pct_r;

  logic [M_W-1:0]       m;
  logic [PP_LO_W-1:0]   pp_lo_nxt;
  logic [PP_HI_W-1:0]   pp_hi_nxt;
  logic [SUM_W-1:0]     sum_full;
  logic [PCT_W-1:0]     pct_full;

  always_comb begin
    en[3] = !v_r[3] || res.ready;
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign jd_ready_o = en[0];

  // The reciprocal is split in two halves so each multiply stays narrow.
  always_comb begin
    m         = {jd_i.n, 1'b1};
    pp_lo_nxt = PP_LO_W'(m) * PP_LO_W'(RECIP[RECIP_LO_W-1:0]);
    pp_hi_nxt = PP_HI_W'(m) * PP_HI_W'(RECIP[RECIP_W-1:RECIP_LO_W]);
    sum_full  = SUM_W'(p1_pp_lo_r) + (SUM_W'(p1_pp_hi_r) << RECIP_LO_W);
    pct_full  = PCT_W'(p3_phase_r) * PCT_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= jd_i.valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && jd_i.valid) begin
      p1_n_r     <= jd_i.n;
      p1_pp_lo_r <= pp_lo_nxt;
      p1_pp_hi_r <= pp_hi_nxt;
    end
    if (en[1] && v_r[0]) begin
      p2_n_r    <= p1_n_r;
      p2_frac_r <= sum_full[PROD_W-1:1];
    end
    if (en[2] && v_r[1]) begin
      p3_n_r     <= p2_n_r;
      p3_phase_r <= p2_frac_r - OFFS;
    end
    if (en[3] && v_r[2]) begin
      p4_n_r   <= p3_n_r;
      p4_pct_r <= pct_full[PCT_W-1:FRAC_BITS];
    end
  end

  assign res.valid            = v_r[3];
  assign res.julian_day_whole = p4_n_r;
  assign res.moon_phase       = p4_pct_r;

endmodule

// ===== bench/moon_phase_from_date_tb.sv =====
`timescale 1ns / 100ps

module moon_phase_from_date_tb;
  import mpfd_pkg::*;

  // One date word as the sender holds it before it goes on the bus.
  typedef struct packed {
    logic [YEAR_W-1:0]  yoff;
    logic [MONTH_W-1:0] mon;
    logic [DAY_W-1:0]   day;
  } date_word_t;

  // The result word that a date is expected to produce.
  typedef struct packed {
    logic [JD_W-1:0]    jd;
    logic [PHASE_W-1:0] phase;
  } lunar_word_t;

  logic clk;
  logic rst_n;

  mpfd_date_if   date_bus();
  mpfd_result_if result_bus();

  moon_phase_from_date dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_date    (date_bus),
    .out_result (result_bus)
  );

  // Dates waiting for the sender, and the results still owed by the block,
  // oldest first.
  date_word_t  date_q[$];
  lunar_word_t phase_due_q[$];

  // Handshake flags captured at the rising edge, consumed at the falling edge.
  logic date_taken;
  logic result_taken;

  // Idle controls. The stimulus process switches them between phases; the
  // hold-off process drives hold_out for one long receiver stall.
  logic src_idle_on;
  logic snk_idle_on;
  logic hold_out;
  int   src_gap;
  int   snk_gap;

  int dates_queued;
  int dates_accepted;
  int results_seen;
  int mismatch_count;

  // The clock runs with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Every input of the block is known from time zero.
  initial begin
    rst_n                   = 1'b0;
    date_bus.valid          = 1'b0;
    date_bus.year_offset    = '0;
    date_bus.month          = '0;
    date_bus.day_of_month   = '0;
    result_bus.ready        = 1'b0;
    date_taken              = 1'b0;
    result_taken            = 1'b0;
    src_idle_on             = 1'b0;
    snk_idle_on             = 1'b0;
    hold_out                = 1'b0;
    src_gap                 = 0;
    snk_gap                 = 0;
    dates_queued            = 0;
    dates_accepted          = 0;
    results_seen            = 0;
    mismatch_count          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Idle span between words: mostly none, often a few cycles, now and then
  // a long one so that gaps land on every stage of the pipeline.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Expected result for one date. The Julian day uses the Gregorian integer
  // formula; every division truncates, and all terms stay positive for any
  // field value the ports can carry, so plain int arithmetic is exact.
  // The phase is frac(JD / synodic month - 0.3033) in fixed point with
  // FRAC_BITS fractional bits. Since JD = N + 0.5, the product is formed
  // from 2N + 1 with one more fractional bit and then halved.
  function automatic lunar_word_t lunar_result_of(date_word_t w);
    int          yr;
    int          shifted;
    int          cent;
    int          n;
    logic [127:0] recip;
    logic [127:0] offs;
    logic [127:0] frac;
    logic [127:0] phase;
    lunar_word_t res;
    yr      = int'(w.yoff) + 2000;
    shifted = 4716 + yr + (int'(w.mon) + 9) / 12;
    cent    = (3 * ((shifted + 83) / 100 + 1)) / 4;
    n       = 1729279 + 367 * yr + (275 * int'(w.mon)) / 9 + int'(w.day) + 38
              - (7 * shifted) / 4 - cent;
    // Round half up: floor((2 * x * 2^F + den) / (2 * den)).
    recip = ((128'd10000000000 << (FRAC_BITS + 1)) + 128'd295305902778)
            / (128'd2 * 128'd295305902778);
    offs  = ((128'd3033 << (FRAC_BITS + 1)) + 128'd10000) / 128'd20000;
    frac  = ((128'(2 * n + 1) * recip) & ((128'd1 << (FRAC_BITS + 1)) - 1)) >> 1;
    phase = (frac - offs) & ((128'd1 << FRAC_BITS) - 1);
    res.jd    = JD_W'(n);
    res.phase = PHASE_W'((phase * 128'd100) >> FRAC_BITS);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("ERROR @ %0t ns: %s", $time, what);
    end
  endtask

  // Sender. A word stays on the bus until it is taken; after each taken word
  // a fresh idle span may follow. During the long receiver stall the sender
  // keeps offering back to back so that the pipeline fills and backs up.
  always @(negedge clk) begin : drive_dates
    int         g;
    date_word_t w;
    g = src_gap;
    if (!rst_n) begin
      date_bus.valid <= 1'b0;
    end else if (!date_bus.valid || date_taken) begin
      if (date_taken && src_idle_on && !hold_out) begin
        g = idle_span();
      end
      if (g > 0) begin
        date_bus.valid <= 1'b0;
        g = g - 1;
      end else if (date_q.size() > 0) begin
        w = date_q.pop_front();
        date_bus.year_offset  <= w.yoff;
        date_bus.month        <= w.mon;
        date_bus.day_of_month <= w.day;
        date_bus.valid        <= 1'b1;
      end else begin
        date_bus.valid <= 1'b0;
      end
    end
    src_gap = g;
  end

  // Receiver. Ready drops for random spans after taken words, and for the
  // whole of the long hold-off.
  always @(negedge clk) begin : drive_ready
    int g;
    g = snk_gap;
    if (result_taken && snk_idle_on) begin
      g = idle_span();
    end
    if (!rst_n || hold_out) begin
      result_bus.ready <= 1'b0;
    end else if (g > 0) begin
      result_bus.ready <= 1'b0;
      g = g - 1;
    end else begin
      result_bus.ready <= 1'b1;
    end
    snk_gap = g;
  end

  // Monitor. The result side is checked before the date side is recorded,
  // so a result can never be matched against a date taken on the same edge.
  always @(posedge clk) begin : watch_bus
    lunar_word_t exp_w;
    date_word_t  got_date;
    if (!rst_n) begin
      date_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      date_taken   <= date_bus.valid && date_bus.ready;
      result_taken <= result_bus.valid && result_bus.ready;
      if (result_bus.valid && result_bus.ready) begin
        results_seen <= results_seen + 1;
        if (phase_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word jd=%0d phase=%0d",
                                    result_bus.julian_day_whole,
                                    result_bus.moon_phase));
        end else begin
          exp_w = phase_due_q.pop_front();
          if (result_bus.julian_day_whole !== exp_w.jd) begin
            report_mismatch($sformatf("julian_day_whole %0d, expected %0d",
                                      result_bus.julian_day_whole, exp_w.jd));
          end
          if (result_bus.moon_phase !== exp_w.phase) begin
            report_mismatch($sformatf("moon_phase %0d, expected %0d (jd %0d)",
                                      result_bus.moon_phase, exp_w.phase,
                                      exp_w.jd));
          end
        end
      end
      if (date_bus.valid && date_bus.ready) begin
        got_date.yoff = date_bus.year_offset;
        got_date.mon  = date_bus.month;
        got_date.day  = date_bus.day_of_month;
        phase_due_q.push_back(lunar_result_of(got_date));
        dates_accepted <= dates_accepted + 1;
      end
    end
  end

  // Long receiver stall, counted here in its own process. It starts well
  // inside the first random phase while the sender is still busy.
  initial begin
    wait (dates_accepted >= 80);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (120) @(posedge clk);
    hold_out <= 1'b0;
  end

  task automatic queue_date(input int y, input int m, input int d);
    date_word_t w;
    w.yoff = YEAR_W'(y);
    w.mon  = MONTH_W'(m);
    w.day  = DAY_W'(d);
    date_q.push_back(w);
    dates_queued++;
  endtask

  // Mostly real calendar dates in 2000 to 2099; the rest are raw bit
  // patterns, which also cover out-of-range months, day zero, days past the
  // month end and years past 2099.
  task automatic queue_random_dates(input int count);
    int y;
    int m;
    int dim;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        y = $urandom_range(0, 99);
        m = $urandom_range(1, 12);
        if (m == 2) begin
          dim = (y % 4 == 0) ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
          dim = 30;
        end else begin
          dim = 31;
        end
        queue_date(y, m, $urandom_range(1, dim));
      end else begin
        queue_date($urandom_range(0, 127), $urandom_range(0, 15),
                   $urandom_range(0, 31));
      end
    end
  endtask

  // Wait until every queued date has come back as a result. This is also
  // where the sender pauses with the pipeline fully drained.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (results_seen < dates_queued);
    @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed dates with light idling on both sides.
    src_idle_on <= 1'b1;
    snk_idle_on <= 1'b1;
    queue_date(0, 1, 1);      // first day of the range
    queue_date(0, 1, 6);      // close to a new moon
    queue_date(0, 2, 29);     // leap day of a century leap year
    queue_date(0, 3, 0);      // day zero rolls back into February
    queue_date(24, 2, 29);    // ordinary leap day
    queue_date(1, 2, 31);     // past the month end rolls into March
    queue_date(99, 12, 31);   // last day of the normal range
    queue_date(100, 2, 29);   // 2100 is not a leap year
    queue_date(127, 15, 31);  // every input bit high
    queue_date(0, 0, 0);      // every input bit low
    queue_date(127, 12, 31);
    queue_date(0, 13, 1);     // months past December
    queue_date(5, 14, 15);
    queue_date(63, 15, 0);
    queue_date(31, 0, 31);    // month zero
    queue_date(50, 6, 15);
    queue_date(26, 4, 30);
    queue_date(42, 10, 16);
    queue_date(85, 8, 8);
    queue_date(10, 11, 23);
    wait_drained();

    // Random dates with idling; the long receiver stall falls in here.
    queue_random_dates(250);
    wait_drained();

    // Full throughput: no gaps on either side.
    src_idle_on <= 1'b0;
    snk_idle_on <= 1'b0;
    queue_random_dates(150);
    wait_drained();

    // Idling again, receiver only, then both sides.
    snk_idle_on <= 1'b1;
    queue_random_dates(100);
    wait_drained();
    src_idle_on <= 1'b1;
    queue_random_dates(150);
    wait_drained();

    // Let any stray result words show up before the verdict.
    repeat (30) @(negedge clk);
    if (phase_due_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", phase_due_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mpfd_pkg.sv
sv/mpfd_date_if.sv
sv/mpfd_result_if.sv
sv/mpfd_julian.sv
sv/mpfd_phase.sv
sv/moon_phase_from_date.sv
bench/moon_phase_from_date_tb.sv
